// ----- hw/rtl/ffba_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Port widths, operation codes, register map, FSM states and the control and
// result records that travel along the row of capacity cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int IDX_W       = 4;
   localparam int SIZE_PORT_W = 16;
   localparam int CNT_W       = 5;
   localparam int APB_ADDR_W  = 3;
   localparam int APB_DATA_W  = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Word index of each register (byte address bit 2).
   localparam logic REG_BLOCK_COUNT = 1'b0;

   localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_PICK
   } ffba_state_type;

   typedef struct packed {
      logic             load;
      logic             compare;
      logic             commit;
      logic [IDX_W-1:0] load_index;
   } ffba_cell_ctl_type;

   typedef struct packed {
      logic                   granted;
      logic [IDX_W-1:0]       chosen_block;
      logic [SIZE_PORT_W-1:0] leftover;
   } ffba_result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ffba_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_csr: configuration register block
// Holds the block count register behind a simple APB slave with no wait
// states.
// ----------------------------------------------------------------------------
module ffba_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ffba_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [ffba_pkg::APB_DATA_W-1:0] pwdata,
   output logic      [ffba_pkg::APB_DATA_W-1:0] prdata,
   output logic                                 pready,
   output logic      [ffba_pkg::CNT_W-1:0]      block_count
);
   import ffba_pkg::*;

   logic [CNT_W-1:0] block_count_ff;
   logic [CNT_W-1:0] block_count_in;
   logic             reg_sel;

   assign reg_sel = (paddr[2] == REG_BLOCK_COUNT);

   always_comb begin
      block_count_in = block_count_ff;
      if (psel && penable && pwrite && reg_sel) begin
         block_count_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   assign prdata      = reg_sel ? {{(APB_DATA_W-CNT_W){1'b0}}, block_count_ff}
                                : '0;
   assign pready      = 1'b1;
   assign block_count = block_count_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ffba_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_cell: one capacity cell of the allocator row
// Keeps the remaining capacity of one memory block, compares it against the
// request size and takes part in the first-fit claim chain with its
// neighbors.
// ----------------------------------------------------------------------------
module ffba_cell #(
   parameter int CELL_IDX   = 0,
   parameter int SIZE_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffba_pkg::ffba_cell_ctl_type   ctl,
   input  wire logic [SIZE_WIDTH-1:0]         size,
   input  wire logic [ffba_pkg::CNT_W-1:0]    block_count,
   input  wire logic                          claim_in,
   output logic                               claim_out,
   input  wire ffba_pkg::ffba_result_type     res_in,
   output ffba_pkg::ffba_result_type          res_out
);
   import ffba_pkg::*;

   localparam logic             LOADABLE = (CELL_IDX < (2 ** IDX_W));
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX % (2 ** IDX_W));

   logic [SIZE_WIDTH-1:0] cap_ff;
   logic [SIZE_WIDTH-1:0] cap_in;
   logic [SIZE_WIDTH-1:0] diff_ff;
   logic [SIZE_WIDTH-1:0] diff_in;
   logic                  fit_ff;
   logic                  fit_in;
   logic                  enable;
   logic                  sel;
   logic [31:0]           diff_wide;

   assign enable = ({{(32-CNT_W){1'b0}}, block_count} > 32'(CELL_IDX));

   // This cell wins when it fits and no lower-numbered cell has claimed.
   assign sel       = fit_ff && !claim_in;
   assign claim_out = claim_in || fit_ff;
   assign diff_wide = 32'(diff_ff);

   always_comb begin
      cap_in  = cap_ff;
      fit_in  = fit_ff;
      diff_in = diff_ff;
      if (ctl.load && LOADABLE && (ctl.load_index == MY_IDX)) begin
         cap_in = size;
      end
      if (ctl.compare) begin
         fit_in  = enable && (cap_ff >= size);
         diff_in = cap_ff - size;
      end
      if (ctl.commit && sel) begin
         cap_in = diff_ff;
      end
   end

   always_comb begin
      res_out = res_in;
      if (sel) begin
         res_out.granted      = 1'b1;
         res_out.chosen_block = MY_IDX;
         res_out.leftover     = diff_wide[SIZE_PORT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
         fit_ff <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         fit_ff <= fit_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_block_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator over a row of capacity cells
// Loads block capacities and grants requests to the first block that fits.
// ----------------------------------------------------------------------------
// A load transaction leaves busy low; the capacity is registered and in place
// for the next transaction. A request transaction keeps busy high through the
// COMPARE and PICK states: in COMPARE every cell compares its capacity with the
// size in parallel, in PICK the claim chain ripples down the cell row, the
// winning cell is charged and the result is registered. The result appears
// with rsp_valid for one cycle right after busy falls; a new transaction may
// start in the cycle the result is shown. The receiver cannot stall:
// rsp_valid is a one-cycle strobe and must be taken when it appears.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_op,
   input  wire logic [ffba_pkg::IDX_W-1:0]        req_block_index,
   input  wire logic [ffba_pkg::SIZE_PORT_W-1:0]  req_size,
   output logic                                   rsp_valid,
   output logic                                   rsp_granted,
   output logic      [ffba_pkg::IDX_W-1:0]        rsp_chosen_block,
   output logic      [ffba_pkg::SIZE_PORT_W-1:0]  rsp_leftover,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ffba_pkg::APB_ADDR_W-1:0]   paddr,
   input  wire logic [ffba_pkg::APB_DATA_W-1:0]   pwdata,
   output logic      [ffba_pkg::APB_DATA_W-1:0]   prdata,
   output logic                                   pready
);
   import ffba_pkg::*;

   ffba_state_type        state_ff;
   ffba_state_type        state_in;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [SIZE_WIDTH-1:0] size_in;
   logic [SIZE_WIDTH-1:0] cell_size;
   logic [31:0]           req_size_wide;
   logic                  accept;
   logic [CNT_W-1:0]      block_count;
   ffba_cell_ctl_type     ctl;
   logic                  claim [MAX_BLOCKS+1];
   ffba_result_type       res   [MAX_BLOCKS+1];
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   ffba_result_type       rsp_ff;
   ffba_result_type       rsp_in;

   ffba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .block_count (block_count)
   );

   assign accept        = start && (state_ff == ST_IDLE);
   assign busy          = (state_ff != ST_IDLE);
   assign req_size_wide = 32'(req_size);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_ALLOC)) begin
               size_in  = req_size_wide[SIZE_WIDTH-1:0];
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            rsp_valid_in = 1'b1;
            rsp_in       = res[MAX_BLOCKS];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      rsp_ff  <= rsp_in;
   end

   // Loads take the size straight from the port; requests use the captured copy.
   assign cell_size      = (state_ff == ST_IDLE) ? req_size_wide[SIZE_WIDTH-1:0] : size_ff;
   assign ctl.load       = accept && (req_op == OP_LOAD);
   assign ctl.compare    = (state_ff == ST_COMPARE);
   assign ctl.commit     = (state_ff == ST_PICK);
   assign ctl.load_index = req_block_index;

   assign claim[0] = 1'b0;
   assign res[0]   = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffba_cell #(
         .CELL_IDX   (i),
         .SIZE_WIDTH (SIZE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .size        (cell_size),
         .block_count (block_count),
         .claim_in    (claim[i]),
         .claim_out   (claim[i+1]),
         .res_in      (res[i]),
         .res_out     (res[i+1])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_ff.granted;
   assign rsp_chosen_block = rsp_ff.chosen_block;
   assign rsp_leftover     = rsp_ff.leftover;

endmodule
`default_nettype wire
